>>> src/cal_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and calendar helpers for the date counter.
// Used by every module of the block; depends on nothing.
package cal_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int MAX_YEAR_DEF = 9999;

  localparam logic [MON_W-1:0] MONTHS = MON_W'(12);

  // 25 * INV25 == 1 modulo 2**YEAR_W; a multiple of 25 maps onto 0..DIV25_LIM
  localparam logic [YEAR_W-1:0] INV25     = YEAR_W'(7209);
  localparam logic [YEAR_W-1:0] DIV25_LIM = YEAR_W'(((1 << YEAR_W) - 1) / 25);

  localparam logic [DAY_W-1:0] DAYS_COMMON [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [DAY_W-1:0] DAYS_LEAP [12] = '{
    5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_BACK    = 2'd1,
    OP_LOAD    = 2'd2
  } cal_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LOAD = 2'd1,
    ST_LIMIT    = 2'd2
  } cal_status_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        opcode;
    logic [DAY_W-1:0]  load_day;
    logic [MON_W-1:0]  load_month;
    logic [YEAR_W-1:0] load_year;
  } cal_item_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic div4;
    logic div16;
    logic div25;
    prod  = y * INV25;
    div4  = (y[1:0] == 2'd0);
    div16 = (y[3:0] == 4'd0);
    div25 = (prod[YEAR_W-1:0] <= DIV25_LIM);
    return div4 && (!div25 || div16);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [MON_W-1:0] idx;
    idx = (m >= MON_W'(1) && m <= MONTHS) ? (m - MON_W'(1)) : '0;
    return leap ? DAYS_LEAP[idx] : DAYS_COMMON[idx];
  endfunction

endpackage

>>> src/calendar_date_counter_top.sv
`timescale 1ns / 1ps
// Gregorian date counter: one transaction per cycle while out_stall is low. An accepted
// operation is held in the input register, and its date update is one pass from there to the
// result register, which holds the result valid; the two registers load on the same edge.
// Synchronous active-low reset gives 1 January of year 1 and empty registers.
// Depends on cal_pkg, cal_in_stage and cal_date_core.
module calendar_date_counter_top #(
  parameter int MAX_YEAR = cal_pkg::MAX_YEAR_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [cal_pkg::DAY_W-1:0]  in_load_day,
  input  logic [cal_pkg::MON_W-1:0]  in_load_month,
  input  logic [cal_pkg::YEAR_W-1:0] in_load_year,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cal_pkg::DAY_W-1:0]  out_day_out,
  output logic [cal_pkg::MON_W-1:0]  out_month_out,
  output logic [cal_pkg::YEAR_W-1:0] out_year_out,
  output logic [1:0]                 out_status
);
  import cal_pkg::*;

  cal_item_t item;
  logic      advance;

  cal_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_load_day   (in_load_day),
    .in_load_month (in_load_month),
    .in_load_year  (in_load_year),
    .advance       (advance),
    .item          (item)
  );

  cal_date_core #(
    .MAX_YEAR (MAX_YEAR)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .item          (item),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_day_out   (out_day_out),
    .out_month_out (out_month_out),
    .out_year_out  (out_year_out),
    .out_status    (out_status)
  );

endmodule

>>> src/cal_in_stage.sv
`timescale 1ns / 1ps
// Input register of the date counter: captures one operation transaction.
// Depends on cal_pkg.
module cal_in_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_opcode,
  input  logic [cal_pkg::DAY_W-1:0]  in_load_day,
  input  logic [cal_pkg::MON_W-1:0]  in_load_month,
  input  logic [cal_pkg::YEAR_W-1:0] in_load_year,
  input  logic                      advance,
  output cal_pkg::cal_item_t        item
);
  import cal_pkg::*;

  cal_item_t item_r;
  cal_item_t item_nxt;

  assign in_stall = item_r.valid && !advance;
  assign item     = item_r;

  always_comb begin
    item_nxt = item_r;
    if (!in_stall) begin
      item_nxt.valid      = in_valid;
      item_nxt.opcode     = in_opcode;
      item_nxt.load_day   = in_load_day;
      item_nxt.load_month = in_load_month;
      item_nxt.load_year  = in_load_year;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else begin
      item_r.valid <= item_nxt.valid;
    end
    item_r.opcode     <= item_nxt.opcode;
    item_r.load_day   <= item_nxt.load_day;
    item_r.load_month <= item_nxt.load_month;
    item_r.load_year  <= item_nxt.load_year;
  end

endmodule

>>> src/cal_date_core.sv
`timescale 1ns / 1ps
// Date registers, day step and load check, and the result register.
// Depends on cal_pkg.
module cal_date_core #(
  parameter int MAX_YEAR = cal_pkg::MAX_YEAR_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cal_pkg::cal_item_t         item,
  output logic                       advance,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cal_pkg::DAY_W-1:0]  out_day_out,
  output logic [cal_pkg::MON_W-1:0]  out_month_out,
  output logic [cal_pkg::YEAR_W-1:0] out_year_out,
  output logic [1:0]                 out_status
);
  import cal_pkg::*;

  localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(MAX_YEAR);

  logic [DAY_W-1:0]  day_r,  day_nxt;
  logic [MON_W-1:0]  mon_r,  mon_nxt;
  logic [YEAR_W-1:0] year_r, year_nxt;
  cal_status_t       st_nxt;

  logic              ov_r;
  logic [DAY_W-1:0]  od_r;
  logic [MON_W-1:0]  om_r;
  logic [YEAR_W-1:0] oy_r;
  logic [1:0]        os_r;

  logic              cur_leap;
  logic              ld_leap;
  logic [DAY_W-1:0]  cur_len;
  logic [DAY_W-1:0]  prev_len;
  logic [DAY_W-1:0]  ld_len;
  logic              ld_bad;
  logic              take;

  assign advance = !ov_r || !out_stall;
  assign take    = item.valid && advance;

  assign cur_leap = is_leap(year_r);
  assign ld_leap  = is_leap(item.load_year);
  assign cur_len  = month_len(mon_r, cur_leap);
  assign prev_len = month_len(mon_r - MON_W'(1), cur_leap);
  assign ld_len   = month_len(item.load_month, ld_leap);
  assign ld_bad   = (item.load_year == '0) || (item.load_year > YEAR_MAX) ||
                    (item.load_month == '0) || (item.load_month > MONTHS) ||
                    (item.load_day == '0) || (item.load_day > ld_len);

  always_comb begin
    day_nxt  = day_r;
    mon_nxt  = mon_r;
    year_nxt = year_r;
    st_nxt   = ST_OK;
    case (cal_op_t'(item.opcode))
      OP_ADVANCE: begin
        if (day_r < cur_len) begin
          day_nxt = day_r + DAY_W'(1);
        end else if (mon_r < MONTHS) begin
          day_nxt = DAY_W'(1);
          mon_nxt = mon_r + MON_W'(1);
        end else if (year_r >= YEAR_MAX) begin
          st_nxt = ST_LIMIT;
        end else begin
          day_nxt  = DAY_W'(1);
          mon_nxt  = MON_W'(1);
          year_nxt = year_r + YEAR_W'(1);
        end
      end
      OP_BACK: begin
        if (day_r > DAY_W'(1)) begin
          day_nxt = day_r - DAY_W'(1);
        end else if (mon_r > MON_W'(1)) begin
          mon_nxt = mon_r - MON_W'(1);
          day_nxt = prev_len;
        end else if (year_r <= YEAR_W'(1)) begin
          st_nxt = ST_LIMIT;
        end else begin
          year_nxt = year_r - YEAR_W'(1);
          mon_nxt  = MONTHS;
          day_nxt  = month_len(MONTHS, 1'b0);
        end
      end
      OP_LOAD: begin
        if (ld_bad) begin
          st_nxt = ST_BAD_LOAD;
        end else begin
          day_nxt  = item.load_day;
          mon_nxt  = item.load_month;
          year_nxt = item.load_year;
        end
      end
      default: begin
        st_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r  <= DAY_W'(1);
      mon_r  <= MON_W'(1);
      year_r <= YEAR_W'(1);
      ov_r   <= 1'b0;
    end else begin
      if (take) begin
        day_r  <= day_nxt;
        mon_r  <= mon_nxt;
        year_r <= year_nxt;
      end
      if (advance) begin
        ov_r <= item.valid;
      end
    end
    if (take) begin
      od_r <= day_nxt;
      om_r <= mon_nxt;
      oy_r <= year_nxt;
      os_r <= st_nxt;
    end
  end

  assign out_valid     = ov_r;
  assign out_day_out   = od_r;
  assign out_month_out = om_r;
  assign out_year_out  = oy_r;
  assign out_status    = os_r;

endmodule

>>> src/cal_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the date counter, bound onto the top level.
// Depends on cal_pkg and calendar_date_counter_top.
module cal_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [cal_pkg::DAY_W-1:0]  out_day_out,
  input logic [cal_pkg::MON_W-1:0]  out_month_out,
  input logic [cal_pkg::YEAR_W-1:0] out_year_out,
  input logic [1:0]                 out_status
);
  import cal_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_day_out) &&
      $stable(out_month_out) && $stable(out_year_out) && $stable(out_status))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_day_out != '0 && out_month_out != '0 &&
      out_month_out <= MONTHS && out_year_out != '0)
    else $error("result date out of range");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_BAD_LOAD ||
      out_status == ST_LIMIT)
    else $error("undefined status code");

endmodule

bind calendar_date_counter_top cal_checker u_cal_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_day_out   (out_day_out),
  .out_month_out (out_month_out),
  .out_year_out  (out_year_out),
  .out_status    (out_status)
);
